FILE: sv/rsbb_pkg.sv
// rotated scaled bounding box: shared types, widths and the cordic arctangent table
// no dependencies; imported by every module of the block
`default_nettype none

package rsbb_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int TURN_BITS    = 24;
   localparam int CORDIC_STEPS = 24;
   localparam int TRIG_FRAC    = 15;
   localparam int SCALE_FRAC   = 8;
   localparam int VEC_FRAC     = 30;
   localparam int EDGE_SHIFT   = SCALE_FRAC + 1 + TRIG_FRAC;

   // cordic vector (q2.30 plus headroom) and angle widths
   localparam int VEC_W = 33;
   localparam int Z_W   = TURN_BITS + 2;
   // |cos| and |sin| in q15, up to and slightly above one
   localparam int MAG_W = TRIG_FRAC + 2;
   // size times scale
   localparam int EXT_W = 31 + 16;

   localparam logic signed [VEC_W-1:0] CORDIC_X0 = 33'sd652032874;

   localparam logic [21:0] ATAN_TABLE [CORDIC_STEPS] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
      22'd41718,   22'd20860,   22'd10430,  22'd5215,   22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81,     22'd41,     22'd20,
      22'd10,      22'd5,       22'd3,      22'd1,      22'd1,      22'd0
   };

   typedef struct packed {
      logic signed [31:0]     rect_x;
      logic signed [31:0]     rect_y;
      logic [30:0]            rect_width;
      logic [30:0]            rect_height;
      logic [ANGLE_BITS-1:0]  angle;
      logic [15:0]            scale;
   } rsbb_req_type;

   typedef struct packed {
      logic signed [31:0]  box_x;
      logic signed [31:0]  box_y;
      logic [30:0]         box_width;
      logic [30:0]         box_height;
   } rsbb_rsp_type;

   typedef struct packed {
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [Z_W-1:0]    z;
   } rsbb_rot_type;

   // geometry that rides alongside the rotation
   typedef struct packed {
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic [30:0]         size_x;
      logic [30:0]         size_y;
      logic [EXT_W-1:0]    ext_x;
      logic [EXT_W-1:0]    ext_y;
   } rsbb_carry_type;

endpackage

`default_nettype wire

FILE: sv/rsbb_cordic_cell.sv
// one rotation-mode cordic cell: a single micro-rotation plus the geometry it carries
// depends on rsbb_pkg
`default_nettype none

module rsbb_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  rsbb_pkg::rsbb_rot_type   in_rot,
   input  rsbb_pkg::rsbb_carry_type in_carry,
   output logic                     out_valid,
   output rsbb_pkg::rsbb_rot_type   out_rot,
   output rsbb_pkg::rsbb_carry_type out_carry
);
   import rsbb_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_TABLE[STEP]);

   logic signed [VEC_W-1:0] x_cur, y_cur, xs, ys;
   logic signed [Z_W-1:0]   z_cur;
   rsbb_rot_type            rot_in, rot_ff;
   rsbb_carry_type          carry_ff;
   logic                    valid_ff;

   always_comb begin
      x_cur = in_rot.x;
      y_cur = in_rot.y;
      z_cur = in_rot.z;
      xs    = y_cur >>> STEP;
      ys    = x_cur >>> STEP;
      if (!z_cur[Z_W-1]) begin
         rot_in.x = x_cur - xs;
         rot_in.y = y_cur + ys;
         rot_in.z = z_cur - ATAN_STEP;
      end else begin
         rot_in.x = x_cur + xs;
         rot_in.y = y_cur - ys;
         rot_in.z = z_cur + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff   <= rot_in;
         carry_ff <= in_carry;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_carry = carry_ff;

endmodule

`default_nettype wire

FILE: sv/rsbb_bounds.sv
// half extents, centre and saturated box edges for both axes, six register stages
// depends on rsbb_pkg
`default_nettype none

module rsbb_bounds (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  rsbb_pkg::rsbb_carry_type in_carry,
   input  logic [rsbb_pkg::MAG_W-1:0] in_cmag,
   input  logic [rsbb_pkg::MAG_W-1:0] in_smag,
   output logic                     out_valid,
   output rsbb_pkg::rsbb_rsp_type   out_box
);
   import rsbb_pkg::*;

   localparam int NSTAGE = 6;
   localparam int LO_W   = 24;
   localparam int HI_W   = EXT_W - LO_W;
   localparam int PROD_W = MAG_W + EXT_W;
   localparam int HALF_W = PROD_W + 1;
   localparam int CEN_W  = 58;
   localparam int SUM_W  = HALF_W + 2;

   localparam logic signed [SUM_W-1:0] CEIL_ADD = SUM_W'((64'd1 << EDGE_SHIFT) - 64'd1);
   localparam logic signed [SUM_W-1:0] EDGE_MAX = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] EDGE_MIN = SUM_W'(signed'(32'h80000000));
   localparam logic signed [32:0]      SPAN_MAX = 33'sd2147483647;

   logic [NSTAGE-1:0] valid_ff;

   // stage 1: partial products and centre
   logic [MAG_W+HI_W-1:0]   pa_hi_in [2], pa_hi_ff [2], pb_hi_in [2], pb_hi_ff [2];
   logic [MAG_W+LO_W-1:0]   pa_lo_in [2], pa_lo_ff [2], pb_lo_in [2], pb_lo_ff [2];
   logic signed [CEN_W-1:0] cen1_in [2], cen1_ff [2], cen2_ff [2], cen3_ff [2];
   // stage 2: full products
   logic [PROD_W-1:0]       pa_in [2], pa_ff [2], pb_in [2], pb_ff [2];
   // stage 3: half extent
   logic [HALF_W-1:0]       half_in [2], half_ff [2];
   // stage 4: unrounded edges
   logic signed [SUM_W-1:0] lo_in [2], lo_ff [2], hi_in [2], hi_ff [2];
   // stage 5: clamped grid edges
   logic signed [31:0]      lower_in [2], lower_ff [2], upper_in [2], upper_ff [2];
   // stage 6: edge and span
   logic signed [31:0]      edge_ff [2];
   logic [30:0]             span_in [2], span_ff [2];

   logic signed [31:0]      pos [2];
   logic [30:0]             size [2];
   logic [EXT_W-1:0]        own [2], other [2];
   logic signed [CEN_W-1:0] pos_s, size_s;
   logic signed [SUM_W-1:0] half_s, lo_sh, hi_sh;
   logic signed [32:0]      span_d;

   function automatic logic signed [31:0] clamp32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > EDGE_MAX) begin
         r = 32'(EDGE_MAX);
      end else if (v < EDGE_MIN) begin
         r = 32'(EDGE_MIN);
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   always_comb begin
      pos[0]   = in_carry.pos_x;
      pos[1]   = in_carry.pos_y;
      size[0]  = in_carry.size_x;
      size[1]  = in_carry.size_y;
      // cos weighs the axis' own extent, sin the other one
      own[0]   = in_carry.ext_x;
      own[1]   = in_carry.ext_y;
      other[0] = in_carry.ext_y;
      other[1] = in_carry.ext_x;
      pos_s    = '0;
      size_s   = '0;
      half_s   = '0;
      lo_sh    = '0;
      hi_sh    = '0;
      span_d   = '0;
      for (int a = 0; a < 2; a++) begin
         pa_hi_in[a] = in_cmag * own[a][EXT_W-1:LO_W];
         pa_lo_in[a] = in_cmag * own[a][LO_W-1:0];
         pb_hi_in[a] = in_smag * other[a][EXT_W-1:LO_W];
         pb_lo_in[a] = in_smag * other[a][LO_W-1:0];
         pos_s       = CEN_W'(pos[a]) <<< EDGE_SHIFT;
         size_s      = CEN_W'(size[a]) << (EDGE_SHIFT - 1);
         cen1_in[a]  = pos_s + size_s;

         pa_in[a] = (PROD_W'(pa_hi_ff[a]) << LO_W) + PROD_W'(pa_lo_ff[a]);
         pb_in[a] = (PROD_W'(pb_hi_ff[a]) << LO_W) + PROD_W'(pb_lo_ff[a]);

         half_in[a] = HALF_W'(pa_ff[a]) + HALF_W'(pb_ff[a]);

         half_s   = SUM_W'(half_ff[a]);
         lo_in[a] = SUM_W'(cen3_ff[a]) - half_s;
         hi_in[a] = SUM_W'(cen3_ff[a]) + half_s;

         // floor for the lower edge, ceiling for the upper edge
         lo_sh       = lo_ff[a] >>> EDGE_SHIFT;
         hi_sh       = (hi_ff[a] + CEIL_ADD) >>> EDGE_SHIFT;
         lower_in[a] = clamp32(lo_sh);
         upper_in[a] = clamp32(hi_sh);

         span_d = 33'(upper_ff[a]) - 33'(lower_ff[a]);
         if (span_d > SPAN_MAX) begin
            span_in[a] = 31'(SPAN_MAX);
         end else begin
            span_in[a] = span_d[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 2; a++) begin
            pa_hi_ff[a] <= pa_hi_in[a];
            pa_lo_ff[a] <= pa_lo_in[a];
            pb_hi_ff[a] <= pb_hi_in[a];
            pb_lo_ff[a] <= pb_lo_in[a];
            cen1_ff[a]  <= cen1_in[a];
            pa_ff[a]    <= pa_in[a];
            pb_ff[a]    <= pb_in[a];
            cen2_ff[a]  <= cen1_ff[a];
            half_ff[a]  <= half_in[a];
            cen3_ff[a]  <= cen2_ff[a];
            lo_ff[a]    <= lo_in[a];
            hi_ff[a]    <= hi_in[a];
            lower_ff[a] <= lower_in[a];
            upper_ff[a] <= upper_in[a];
            edge_ff[a]  <= lower_ff[a];
            span_ff[a]  <= span_in[a];
         end
      end
   end

   assign out_valid          = valid_ff[NSTAGE-1];
   assign out_box.box_x      = edge_ff[0];
   assign out_box.box_y      = edge_ff[1];
   assign out_box.box_width  = span_ff[0];
   assign out_box.box_height = span_ff[1];

endmodule

`default_nettype wire

FILE: sv/rotated_scaled_bounding_box_unit.sv
// rotated scaled bounding box, top level: entry stage, cordic cell row, rounding, bounds, output
// depends on rsbb_pkg, rsbb_cordic_cell, rsbb_bounds
`default_nettype none

//  channel   direction  ports                          item
//  request   in         req_valid req_stall req_data   rectangle, angle, scale
//  response  out        rsp_valid rsp_stall rsp_data   enclosing axis-aligned box
//
//  one item enters per cycle while the pipe is not held; each item passes through
//  the entry stage, 24 cordic cells, rounding stage, 6 bounds stages and output register
//  the depth is set by the 24-cell cordic row
//  reset clears every valid flag; the payload registers are not reset
//  the whole pipe holds only when its last stage has an item and the output
//  register is full and stalled, so the request side keeps flowing otherwise

module rotated_scaled_bounding_box_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rsbb_pkg::rsbb_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsbb_pkg::rsbb_rsp_type rsp_data
);
   import rsbb_pkg::*;

   localparam logic signed [Z_W-1:0]   HALF_TURN  = Z_W'(1) <<< (TURN_BITS - 1);
   localparam logic signed [Z_W-1:0]   FULL_TURN  = Z_W'(1) <<< TURN_BITS;
   localparam logic signed [VEC_W-1:0] ROUND_HALF = VEC_W'(1) <<< (VEC_FRAC - TRIG_FRAC - 1);

   // pipe advance
   logic en;
   logic out_free;

   // entry stage
   logic [TURN_BITS-1:0] turn;
   logic signed [Z_W-1:0] turn_s;
   rsbb_rot_type   ent_rot_in;
   rsbb_carry_type ent_carry_in;

   // cordic row, index 0 is the entry stage register
   logic [CORDIC_STEPS:0] valid_chain;
   rsbb_rot_type          rot_chain   [CORDIC_STEPS+1];
   rsbb_carry_type        carry_chain [CORDIC_STEPS+1];
   logic                  ent_valid_ff;
   rsbb_rot_type          ent_rot_ff;
   rsbb_carry_type        ent_carry_ff;

   // rounding stage
   logic                 rnd_valid_ff;
   logic [MAG_W-1:0]     cmag_in, cmag_ff, smag_in, smag_ff;
   rsbb_carry_type       rnd_carry_ff;

   // bounds and output
   logic                 bnd_valid;
   rsbb_rsp_type         bnd_box;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsbb_rsp_type         rsp_data_ff;

   // round a q2.30 cordic output to q15 and take its magnitude
   function automatic logic [MAG_W-1:0] mag_q15(input logic signed [VEC_W-1:0] v);
      logic signed [VEC_W-1:0] r;
      logic signed [MAG_W:0]   q;
      logic signed [MAG_W:0]   m;
      r = v + ROUND_HALF;
      q = r[VEC_W-1:VEC_FRAC-TRIG_FRAC];
      m = q[MAG_W] ? -q : q;
      return m[MAG_W-1:0];
   endfunction

   // output register frees up when empty or when its item is taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign en        = out_free || !bnd_valid;
   assign req_stall = !en;

   // angle to a 24-bit turn, folded to within a quarter turn of zero
   always_comb begin
      turn   = TURN_BITS'(req_data.angle) << (TURN_BITS - ANGLE_BITS);
      turn_s = Z_W'(turn);
      if (turn[TURN_BITS-1] ^ turn[TURN_BITS-2]) begin
         ent_rot_in.z = turn_s - HALF_TURN;
      end else if (turn[TURN_BITS-1]) begin
         ent_rot_in.z = turn_s - FULL_TURN;
      end else begin
         ent_rot_in.z = turn_s;
      end
      ent_rot_in.x        = CORDIC_X0;
      ent_rot_in.y        = '0;
      ent_carry_in.pos_x  = req_data.rect_x;
      ent_carry_in.pos_y  = req_data.rect_y;
      ent_carry_in.size_x = req_data.rect_width;
      ent_carry_in.size_y = req_data.rect_height;
      // sizes times scale, 31 by 16 bits
      ent_carry_in.ext_x  = EXT_W'(req_data.rect_width * req_data.scale);
      ent_carry_in.ext_y  = EXT_W'(req_data.rect_height * req_data.scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (en) begin
         ent_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_rot_ff   <= ent_rot_in;
         ent_carry_ff <= ent_carry_in;
      end
   end

   assign valid_chain[0] = ent_valid_ff;
   assign rot_chain[0]   = ent_rot_ff;
   assign carry_chain[0] = ent_carry_ff;

   // row of cordic cells, one micro-rotation each
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      rsbb_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_chain[i]),
         .in_rot    (rot_chain[i]),
         .in_carry  (carry_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_rot   (rot_chain[i+1]),
         .out_carry (carry_chain[i+1])
      );
   end

   // |cos| and |sin| in q15
   assign cmag_in = mag_q15(rot_chain[CORDIC_STEPS].x);
   assign smag_in = mag_q15(rot_chain[CORDIC_STEPS].y);

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (en) begin
         rnd_valid_ff <= valid_chain[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmag_ff      <= cmag_in;
         smag_ff      <= smag_in;
         rnd_carry_ff <= carry_chain[CORDIC_STEPS];
      end
   end

   rsbb_bounds u_bounds (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rnd_valid_ff),
      .in_carry  (rnd_carry_ff),
      .in_cmag   (cmag_ff),
      .in_smag   (smag_ff),
      .out_valid (bnd_valid),
      .out_box   (bnd_box)
   );

   // output register, loads whenever the held item has gone
   assign rsp_valid_in = out_free ? bnd_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= bnd_box;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: test/tb_rotated_scaled_bounding_box_unit.sv
// self-checking testbench for rotated_scaled_bounding_box_unit: directed and random rectangles,
// checked against a cordic-based bounding box predictor under random idling and back-pressure
// depends on rsbb_pkg (port types) and the rotated_scaled_bounding_box_unit rtl
`default_nettype none

module tb_rotated_scaled_bounding_box_unit;

   import rsbb_pkg::rsbb_req_type;
   import rsbb_pkg::rsbb_rsp_type;

   // predictor constants: 24-bit turn, 16-bit angle field, q15 trig, 24-bit edge shift
   localparam int     TURN_W      = 24;
   localparam int     ANGLE_W     = 16;
   localparam int     STEPS       = 24;
   localparam int     ROUND_SHIFT = 15;
   localparam int     EDGE_SH     = 24;
   localparam longint QUARTER     = 64'sd1 <<< (TURN_W - 2);
   localparam longint GAIN_INV    = 64'sd652032874;
   localparam longint MAX32       = 64'sd2147483647;
   localparam longint MIN32       = -64'sd2147483648;

   localparam longint ARCTAN [STEPS] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0
   };

   // pressure and run shape
   localparam int RANDOM_RECTS = 900;
   localparam int HOLD_AT      = 300;   // long receiver hold-off starts after this many items
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_AT     = 450;   // random item that waits for an empty pipe
   localparam int CALM_LO      = 650;   // window with no idling on either side
   localparam int CALM_HI      = 750;
   localparam int TAIL_RECTS   = 120;   // last items run with no idling
   localparam int SETTLE       = 40;    // pipe is 33 deep

   typedef struct {
      bit            wait_drain;
      rsbb_req_type  rect;
   } rect_entry_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   rsbb_req_type  req_data    = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   rsbb_rsp_type  rsp_data;

   rect_entry_type rect_queue[$];
   rsbb_rsp_type   pending_boxes[$];

   int rects_taken   = 0;
   int boxes_checked = 0;
   int item_total    = 0;
   int error_count   = 0;
   int gap_left      = 0;
   int stall_left    = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   rotated_scaled_bounding_box_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 time unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic longint sat32(input longint v);
      if (v > MAX32)
         return MAX32;
      if (v < MIN32)
         return MIN32;
      return v;
   endfunction

   // one axis: floor of the low edge, ceiling of the high edge, both clamped
   function automatic void axis_bounds(input longint pos, input longint size,
                                       input longint half, output longint lo_edge,
                                       output longint span);
      longint centre, hi_edge;
      centre  = pos * (64'sd1 <<< EDGE_SH) + size * (64'sd1 <<< (EDGE_SH - 1));
      lo_edge = sat32((centre - half) >>> EDGE_SH);
      hi_edge = sat32(-((-(centre + half)) >>> EDGE_SH));
      span    = hi_edge - lo_edge;
      if (span > MAX32)
         span = MAX32;
   endfunction

   function automatic rsbb_rsp_type enclosing_box(input rsbb_req_type r);
      longint z, x, y, xs, ys, c, s, cmag, smag;
      longint ext_x, ext_y, half_x, half_y, bx, by, bw, bh;
      rsbb_rsp_type b;
      // fold the angle into a quarter turn either side of zero
      z = longint'({40'd0, r.angle, 8'd0});
      if (z >= QUARTER && z < 3 * QUARTER)
         z = z - 2 * QUARTER;
      else if (z >= 3 * QUARTER)
         z = z - 4 * QUARTER;
      x = GAIN_INV;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = y >>> i;
         ys = x >>> i;
         if (z >= 0) begin
            x = x - xs;
            y = y + ys;
            z = z - ARCTAN[i];
         end else begin
            x = x + xs;
            y = y - ys;
            z = z + ARCTAN[i];
         end
      end
      c = (x + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      s = (y + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      cmag = (c < 0) ? -c : c;
      smag = (s < 0) ? -s : s;
      ext_x  = longint'({33'd0, r.rect_width}) * longint'({48'd0, r.scale});
      ext_y  = longint'({33'd0, r.rect_height}) * longint'({48'd0, r.scale});
      half_x = cmag * ext_x + smag * ext_y;
      half_y = smag * ext_x + cmag * ext_y;
      axis_bounds(longint'(r.rect_x), longint'({33'd0, r.rect_width}), half_x, bx, bw);
      axis_bounds(longint'(r.rect_y), longint'({33'd0, r.rect_height}), half_y, by, bh);
      b.box_x      = bx[31:0];
      b.box_y      = by[31:0];
      b.box_width  = bw[30:0];
      b.box_height = bh[30:0];
      return b;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic rsbb_req_type make_rect(input int x, input int y, input int unsigned w,
                                              input int unsigned h, input int unsigned a,
                                              input int unsigned sc);
      rsbb_req_type r;
      r.rect_x      = x;
      r.rect_y      = y;
      r.rect_width  = w[30:0];
      r.rect_height = h[30:0];
      r.angle       = a[15:0];
      r.scale       = sc[15:0];
      return r;
   endfunction

   // mostly sprite-sized rectangles, some with every bit random, some at the range limits
   function automatic rsbb_req_type random_rect();
      rsbb_req_type r;
      int unsigned  kind;
      kind = $urandom_range(0, 99);
      r = make_rect($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (kind < 65) begin
         r.rect_x      = int'($urandom_range(0, 2097152)) - 1048576;
         r.rect_y      = int'($urandom_range(0, 2097152)) - 1048576;
         r.rect_width  = 31'($urandom_range(0, 262144));
         r.rect_height = 31'($urandom_range(0, 262144));
         r.scale       = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 1023));
      end else if (kind >= 85) begin
         case ($urandom_range(0, 2))
            0: r.rect_x = 32'h7FFFFFFF - $urandom_range(0, 255);
            1: r.rect_x = 32'h80000000 + $urandom_range(0, 255);
            default: ;
         endcase
         case ($urandom_range(0, 2))
            0: r.rect_y = 32'h7FFFFFFF - $urandom_range(0, 255);
            1: r.rect_y = 32'h80000000 + $urandom_range(0, 255);
            default: ;
         endcase
         r.rect_width  = r.rect_width | 31'h7F000000;
         r.rect_height = r.rect_height | 31'h7F000000;
         r.scale       = r.scale | 16'hF000;
      end
      return r;
   endfunction

   task automatic queue_rect(input rsbb_req_type r, input bit drain);
      rect_entry_type e;
      e.wait_drain = drain;
      e.rect       = r;
      rect_queue.push_back(e);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("box %0d: %s is %0d, expected %0d", boxes_checked, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // driver: offers rectangles from rect_queue, predicts each accepted item
   // ------------------------------------------------------------------
   always @(posedge clock) begin : driver
      int  taken_now;
      bit  quiet;
      taken_now = rects_taken;
      quiet = (rects_taken >= item_total - TAIL_RECTS) || (hold_left > 0) ||
              (rects_taken >= CALM_LO && rects_taken < CALM_HI);
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_boxes.push_back(enclosing_box(req_data));
            taken_now = rects_taken + 1;
            rects_taken <= taken_now;
         end
         // a stalled item stays put; the slot only moves once the item is taken
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (rect_queue.size() == 0 ||
                         (rect_queue[0].wait_drain && taken_now != boxes_checked)) begin
               // nothing left, or holding off until every box is back
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               // idle burst: this slot idles, then gap_left more slots
               gap_left  <= $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else begin
               req_data  <= rect_queue[0].rect;
               req_valid <= 1'b1;
               void'(rect_queue.pop_front());
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver stall: random bursts, one long hold-off to fill the pipe
   // ------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      bit quiet;
      quiet = (rects_taken >= item_total - TAIL_RECTS) ||
              (rects_taken >= CALM_LO && rects_taken < CALM_HI);
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rects_taken >= HOLD_AT) begin
         // the sender keeps offering meanwhile, so the block backs up to its input
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // monitor: each accepted box against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsbb_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_boxes.size() == 0) begin
            report_mismatch("unexpected box_x", longint'(rsp_data.box_x), 0);
         end else begin
            want = pending_boxes.pop_front();
            if (rsp_data.box_x !== want.box_x)
               report_mismatch("box_x", longint'(rsp_data.box_x), longint'(want.box_x));
            if (rsp_data.box_y !== want.box_y)
               report_mismatch("box_y", longint'(rsp_data.box_y), longint'(want.box_y));
            if (rsp_data.box_width !== want.box_width)
               report_mismatch("box_width", longint'({33'd0, rsp_data.box_width}),
                               longint'({33'd0, want.box_width}));
            if (rsp_data.box_height !== want.box_height)
               report_mismatch("box_height", longint'({33'd0, rsp_data.box_height}),
                               longint'({33'd0, want.box_height}));
            boxes_checked <= boxes_checked + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      int unsigned turn_points [12];
      turn_points = '{16'h0000, 16'h2000, 16'h3FFF, 16'h4000, 16'h6000, 16'h8000,
                      16'hA000, 16'hBFFF, 16'hC000, 16'hE000, 16'hFFFF, 16'h1357};

      // all zero, then unity scale across the octant and quadrant boundaries
      queue_rect(make_rect(0, 0, 0, 0, 0, 0), 1'b0);
      foreach (turn_points[i])
         queue_rect(make_rect(-32'sh4000, 32'sh2000, 32'h1000, 32'h300, turn_points[i],
                              16'h0100), 1'b0);
      // edges off the top of the range, and both ends with size saturation
      queue_rect(make_rect(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           16'h2000, 16'hFFFF), 1'b0);
      queue_rect(make_rect(int'(32'h80000000), int'(32'h80000000), 32'h7FFFFFFF,
                           32'h7FFFFFFF, 16'h2000, 16'hFFFF), 1'b0);
      queue_rect(make_rect(int'(32'h80000000), int'(32'h80000000), 0, 0, 0, 0), 1'b0);
      // zero scale, centre on the grid and off it
      queue_rect(make_rect(32'sh1234, -32'sh800, 32'h200, 32'h400, 16'h1357, 0), 1'b0);
      queue_rect(make_rect(-5, 7, 1, 3, 16'h9ABC, 0), 1'b0);
      // all ones, a thin rectangle at opposite corners, tiny scale
      queue_rect(make_rect(-1, -1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
      queue_rect(make_rect(32'sh7FFFFFFF, int'(32'h80000000), 32'h7FFFFFFF, 1, 0, 1), 1'b0);
      queue_rect(make_rect(32'sh10000, -32'sh10000, 32'h100, 32'h100, 16'h0800, 1), 1'b0);

      for (int i = 0; i < RANDOM_RECTS; i++)
         queue_rect(random_rect(), i == DRAIN_AT);
      item_total = rect_queue.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (rects_taken != item_total || boxes_checked != rects_taken)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (pending_boxes.size() != 0)
         report_mismatch("boxes never returned", 0, longint'(pending_boxes.size()));
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // generous watchdog, several times the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
